FILE: rtl/scfb_pkg.sv
// Shared types, field widths and ATA codes for the command FIS builder.
// No dependencies; imported by the controller, datapath, top level and checker.
package scfb_pkg;

    // Transfer geometry
    localparam int SECTOR_BYTES    = 512;
    localparam int MAX_PRD         = 8;
    localparam int PRD_MAX_BYTES   = 4194304;
    localparam int MAX_COMMANDS    = 4;
    localparam int PRD_SECTORS     = PRD_MAX_BYTES / SECTOR_BYTES;
    localparam int PER_CMD_SECTORS = PRD_SECTORS * MAX_PRD;
    localparam int MAX_SECTORS     = PER_CMD_SECTORS * MAX_COMMANDS;
    localparam int SECTOR_SHIFT    = $clog2(SECTOR_BYTES);
    localparam int PRD_SHIFT       = $clog2(PRD_SECTORS);

    // Field widths
    localparam int OP_W           = 2;
    localparam int LBA_W          = 48;
    localparam int COUNT_W        = 19;
    localparam int ADDR_W         = 64;
    localparam int KIND_W         = 2;
    localparam int OPCODE_W       = 8;
    localparam int FIS_COUNT_W    = 16;
    localparam int DEVICE_W       = 8;
    localparam int ENTRY_TOTAL_W  = 4;
    localparam int ENTRY_BYTES_W  = 22;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 48;
    localparam int CHUNK_W        = $clog2(PER_CMD_SECTORS + 1);
    localparam int PIECE_W        = $clog2(PRD_SECTORS + 1);
    localparam int PIECE_BYTES_W  = PIECE_W + SECTOR_SHIFT;
    localparam int IN_DATA_W      = 136;
    localparam int OUT_DATA_W     = 176;

    // 28-bit form limits and device byte
    localparam logic [LBA_W-1:0]    LBA28_MAX   = 48'h0000_0FFF_FFFF;
    localparam int                  COUNT28_MAX = 8'hFF;
    localparam logic [DEVICE_W-1:0] DEVICE_LBA  = 8'h40;

    // ATA command bytes
    localparam logic [OPCODE_W-1:0] ATA_READ_DMA      = 8'hC8;
    localparam logic [OPCODE_W-1:0] ATA_READ_DMA_EXT  = 8'h25;
    localparam logic [OPCODE_W-1:0] ATA_WRITE_DMA     = 8'hCA;
    localparam logic [OPCODE_W-1:0] ATA_WRITE_DMA_EXT = 8'h35;
    localparam logic [OPCODE_W-1:0] ATA_FLUSH         = 8'hE7;
    localparam logic [OPCODE_W-1:0] ATA_FLUSH_EXT     = 8'hEA;

    // Request operations
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;

    // Result item kinds
    localparam logic [KIND_W-1:0] KIND_FIS    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LBA48    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit_fis;
        logic emit_entry;
        logic emit_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic req_flush;
        logic req_reject;
        logic req_empty;
        logic run_flush;
        logic entry_last;
        logic run_done;
        logic out_free;
    } t_dp_status;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]        item_kind;
        logic [OPCODE_W-1:0]      ata_opcode;
        logic [LBA_W-1:0]         fis_lba;
        logic [FIS_COUNT_W-1:0]   fis_count;
        logic [DEVICE_W-1:0]      device_byte;
        logic                     write_flag;
        logic [ENTRY_TOTAL_W-1:0] entry_total;
        logic [ADDR_W-1:0]        entry_address;
        logic [ENTRY_BYTES_W-1:0] entry_bytes_less_one;
        logic                     entry_interrupt;
        logic                     status;
        logic                     last;
    } t_out_item;

endpackage

FILE: rtl/scfb_ctrl.sv
// Run sequencer for the command FIS builder: FIS, scatter entries, status.
// Depends on scfb_pkg; drives scfb_dp through t_dp_cmd.
module scfb_ctrl import scfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIS,
        S_ENTRY,
        S_STATUS
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.req_flush) begin
                        n_state = S_FIS;
                    end else if (i_stat.req_reject || i_stat.req_empty) begin
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_FIS;
                    end
                end
            end
            S_FIS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_fis = 1'b1;
                    n_state = i_stat.run_flush ? S_STATUS : S_ENTRY;
                end
            end
            S_ENTRY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_stat.entry_last) begin
                        n_state = i_stat.run_done ? S_STATUS : S_FIS;
                    end
                end
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/scfb_dp.sv
// Datapath of the command FIS builder: config registers, run cursors and
// the result item register. Depends on scfb_pkg; commanded by scfb_ctrl.
module scfb_dp import scfb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [LBA_W-1:0]      i_start_lba,
    input  logic [COUNT_W-1:0]    i_num_sectors,
    input  logic [ADDR_W-1:0]     i_buffer_address,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic             r_lba48;
    logic [LBA_W-1:0] r_capacity;

    logic                 r_flush;
    logic                 r_write;
    logic                 r_status;
    logic [COUNT_W-1:0]   r_sectors_left;
    logic [LBA_W-1:0]     r_lba;
    logic [ADDR_W-1:0]    r_addr;
    logic [CHUNK_W-1:0]   r_cmd_left;

    logic                 r_out_valid;
    t_out_item            r_item;
    t_out_item            n_item;

    logic [LBA_W:0]         w_end_lba;
    logic [CHUNK_W-1:0]     w_chunk;
    logic                   w_use48;
    logic [CHUNK_W:0]       w_total_sum;
    logic [CHUNK_W:0]       w_total;
    logic [PIECE_W-1:0]     w_piece;
    logic [PIECE_BYTES_W-1:0] w_piece_bytes;
    logic [PIECE_BYTES_W-1:0] w_piece_less;
    logic                   w_emit;

    // Request checks on the incoming item
    assign w_end_lba = {1'b0, i_start_lba} + (LBA_W + 1)'(i_num_sectors);
    assign o_stat.req_flush  = i_operation[1];
    assign o_stat.req_reject = (w_end_lba > {1'b0, r_capacity})
                            || (32'(i_num_sectors) > MAX_SECTORS);
    assign o_stat.req_empty  = (i_num_sectors == '0);

    // Command split: sectors for this command and its form
    assign w_chunk = (r_sectors_left > COUNT_W'(PER_CMD_SECTORS))
                   ? CHUNK_W'(PER_CMD_SECTORS) : r_sectors_left[CHUNK_W-1:0];
    assign w_use48 = r_lba48 && ((r_lba > LBA28_MAX) || (w_chunk > CHUNK_W'(COUNT28_MAX)));
    assign w_total_sum = {1'b0, w_chunk} + (CHUNK_W + 1)'(PRD_SECTORS - 1);
    assign w_total     = w_total_sum >> PRD_SHIFT;

    // Scatter piece: up to one full PRD of sectors
    assign w_piece = (r_cmd_left > CHUNK_W'(PRD_SECTORS))
                   ? PIECE_W'(PRD_SECTORS) : r_cmd_left[PIECE_W-1:0];
    assign w_piece_bytes = PIECE_BYTES_W'(w_piece) << SECTOR_SHIFT;
    assign w_piece_less  = w_piece_bytes - PIECE_BYTES_W'(1);

    assign o_stat.run_flush  = r_flush;
    assign o_stat.entry_last = (r_cmd_left <= CHUNK_W'(PRD_SECTORS));
    assign o_stat.run_done   = (r_sectors_left == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign w_emit = i_cmd.emit_fis || i_cmd.emit_entry || i_cmd.emit_status;

    // Result item assembly
    always_comb begin
        n_item = '0;
        if (i_cmd.emit_fis) begin
            n_item.item_kind = KIND_FIS;
            if (r_flush) begin
                n_item.ata_opcode  = r_lba48 ? ATA_FLUSH_EXT : ATA_FLUSH;
                n_item.device_byte = DEVICE_LBA;
            end else begin
                if (r_write) begin
                    n_item.ata_opcode = w_use48 ? ATA_WRITE_DMA_EXT : ATA_WRITE_DMA;
                end else begin
                    n_item.ata_opcode = w_use48 ? ATA_READ_DMA_EXT : ATA_READ_DMA;
                end
                if (w_use48) begin
                    n_item.fis_lba     = r_lba;
                    n_item.fis_count   = w_chunk[FIS_COUNT_W-1:0];
                    n_item.device_byte = DEVICE_LBA;
                end else begin
                    n_item.fis_lba     = {24'h0, r_lba[23:0]};
                    n_item.fis_count   = {8'h0, w_chunk[7:0]};
                    n_item.device_byte = DEVICE_LBA | {4'h0, r_lba[27:24]};
                end
                n_item.write_flag  = r_write;
                n_item.entry_total = w_total[ENTRY_TOTAL_W-1:0];
            end
        end else if (i_cmd.emit_entry) begin
            n_item.item_kind            = KIND_ENTRY;
            n_item.entry_address        = r_addr;
            n_item.entry_bytes_less_one = w_piece_less[ENTRY_BYTES_W-1:0];
            n_item.entry_interrupt      = o_stat.entry_last;
        end else if (i_cmd.emit_status) begin
            n_item.item_kind = KIND_STATUS;
            n_item.status    = r_status;
            n_item.last      = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba48    <= 1'b0;
            r_capacity <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LBA48:    r_lba48    <= i_cfg_wdata[0];
                CFG_CAPACITY: r_capacity <= i_cfg_wdata[LBA_W-1:0];
                default:      r_lba48    <= r_lba48;
            endcase
        end
    end

    // Run cursors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sectors_left <= '0;
            r_lba          <= '0;
            r_addr         <= '0;
            r_cmd_left     <= '0;
            r_flush        <= 1'b0;
            r_write        <= 1'b0;
            r_status       <= 1'b0;
        end else if (i_cmd.load) begin
            r_flush        <= o_stat.req_flush;
            r_write        <= (i_operation == OP_WRITE);
            r_status       <= !o_stat.req_flush && o_stat.req_reject;
            r_sectors_left <= i_num_sectors;
            r_lba          <= i_start_lba;
            r_addr         <= i_buffer_address;
        end else if (i_cmd.emit_fis && !r_flush) begin
            r_cmd_left     <= w_chunk;
            r_sectors_left <= r_sectors_left - COUNT_W'(w_chunk);
            r_lba          <= r_lba + LBA_W'(w_chunk);
        end else if (i_cmd.emit_entry) begin
            r_cmd_left <= r_cmd_left - CHUNK_W'(w_piece);
            r_addr     <= r_addr + ADDR_W'(w_piece_bytes);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_item <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_item;

endmodule

FILE: rtl/sata_command_fis_builder_core.sv
// Top level of the SATA command FIS and scatter list builder.
// Depends on scfb_pkg, scfb_ctrl and scfb_dp.
//
// Usage:
//   s_axis carries one block request per item (read, write or flush).
//   m_axis returns its run: per command one register FIS item and one
//   scatter entry per 4 MiB piece, then one status item marked by tlast.
//   The config port writes lba48_enabled (index 0) and capacity_sectors
//   (index 1); write it only while no run is in flight.
// Run sequencing:
//   After a request is taken, the sequencer moves from idle to its FIS or
//   status state; that state loads the first item into the output register.
//   Results leave, and the sequencer steps, at one item per cycle unless a
//   low m_axis_tready stalls them; a run has N items (1 to 37: status only,
//   flush FIS plus status, or up to 4 x (1 FIS + 8 entries) plus status).
//   s_axis_tready is high again as soon as the status item is loaded into
//   the output register, while that item still waits to be taken.
// Reset and stall:
//   Synchronous reset clears the sequencer, the output valid and both
//   config registers. A low m_axis_tready holds the current item and
//   pauses the sequencer; nothing is dropped.
module sata_command_fis_builder_core import scfb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: start_lba[47:0], num_sectors[66:48], buffer_address[130:67], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: ata_opcode[7:0], fis_lba[55:8], fis_count[71:56], device_byte[79:72],
    //        write_flag[80], entry_total[84:81], entry_address[148:85],
    //        entry_bytes_less_one[170:149], entry_interrupt[171], status[172], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: item_kind[1:0]
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;
    t_out_item  w_item;

    scfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    scfb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (s_axis_tuser),
        .i_start_lba      (s_axis_tdata[47:0]),
        .i_num_sectors    (s_axis_tdata[66:48]),
        .i_buffer_address (s_axis_tdata[130:67]),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_out_item       (w_item)
    );

    // Pack the result item onto the stream
    assign m_axis_tdata = {
        3'b000,
        w_item.status,
        w_item.entry_interrupt,
        w_item.entry_bytes_less_one,
        w_item.entry_address,
        w_item.entry_total,
        w_item.write_flag,
        w_item.device_byte,
        w_item.fis_count,
        w_item.fis_lba,
        w_item.ata_opcode
    };
    assign m_axis_tuser = w_item.item_kind;
    assign m_axis_tlast = w_item.last;

endmodule

FILE: rtl/scfb_checker.sv
// Port-level checks for the SATA command FIS builder, bound to the top level.
// Depends on scfb_pkg and sata_command_fis_builder_core.
module scfb_checker import scfb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Exactly the status item closes a run
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_STATUS)))
        else $error("tlast does not match status kind");

    // One request at a time: ready drops after a request is taken
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken during a run");

    // A stalled result item holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result item changed");

endmodule

bind sata_command_fis_builder_core scfb_checker u_scfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/sata_command_fis_builder_core_test.sv
// Self-checking testbench for sata_command_fis_builder_core: block requests in, FIS/PRD runs out.
// Depends on rtl/scfb_pkg.sv and the core; a built-in run predictor scores every output item.
module sata_command_fis_builder_core_test;
    import scfb_pkg::*;

    // Operations the package leaves unnamed
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_MAX     = 10;
    localparam logic [LBA_W-1:0] LBA_TOP = 48'hFFFF_FFFF_FFFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // Local copy of the config registers
    logic             model_lba48;
    logic [LBA_W-1:0] model_capacity;

    // Items still owed by the core, oldest first
    t_out_item run_items_due[$];

    int mismatch_count;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_trigger;
    int hold_ack;
    int hold_left;
    int quiet_cycles;

    sata_command_fis_builder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic string describe_item(t_out_item it);
        return $sformatf({"kind=%0d op=%h lba=%h cnt=%h dev=%h wr=%b tot=%0d ",
                          "addr=%h len1=%h irq=%b st=%b last=%b"},
                         it.item_kind, it.ata_opcode, it.fis_lba, it.fis_count,
                         it.device_byte, it.write_flag, it.entry_total, it.entry_address,
                         it.entry_bytes_less_one, it.entry_interrupt, it.status, it.last);
    endfunction

    task automatic note_failure(input string msg);
        if (mismatch_count < REPORT_MAX)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic push_status(input logic rejected);
        t_out_item it;
        it = '0;
        it.item_kind = KIND_STATUS;
        it.status    = rejected;
        it.last      = 1'b1;
        run_items_due.push_back(it);
    endtask

    // Builds the whole run the core owes for one request
    task automatic predict_run(input logic [OP_W-1:0] op, input logic [LBA_W-1:0] lba,
                               input logic [COUNT_W-1:0] cnt, input logic [ADDR_W-1:0] addr);
        t_out_item        it;
        logic [COUNT_W-1:0] left;
        logic [LBA_W-1:0] cur_lba;
        logic [ADDR_W-1:0] cur_addr;
        logic [ADDR_W-1:0] cursor;
        logic [31:0]      chunk;
        logic [31:0]      bytes_left;
        logic [31:0]      piece;
        int               n_entries;
        int               k;
        logic             wide;

        // Flush, and the spare code that behaves as one
        if (op[1]) begin
            it = '0;
            it.item_kind   = KIND_FIS;
            it.ata_opcode  = model_lba48 ? ATA_FLUSH_EXT : ATA_FLUSH;
            it.device_byte = DEVICE_LBA;
            run_items_due.push_back(it);
            push_status(1'b0);
            return;
        end

        // Range beyond capacity, or more commands than allowed
        if (({16'd0, lba} + {45'd0, cnt}) > {16'd0, model_capacity} || cnt > MAX_SECTORS) begin
            push_status(1'b1);
            return;
        end

        left     = cnt;
        cur_lba  = lba;
        cur_addr = addr;
        while (left != 0) begin
            chunk      = (left < PER_CMD_SECTORS) ? 32'(left) : 32'(PER_CMD_SECTORS);
            bytes_left = chunk * SECTOR_BYTES;
            n_entries  = (bytes_left + PRD_MAX_BYTES - 1) / PRD_MAX_BYTES;
            wide       = model_lba48 && (cur_lba > LBA28_MAX || chunk > COUNT28_MAX);

            it = '0;
            it.item_kind = KIND_FIS;
            if (op == OP_WRITE)
                it.ata_opcode = wide ? ATA_WRITE_DMA_EXT : ATA_WRITE_DMA;
            else
                it.ata_opcode = wide ? ATA_READ_DMA_EXT : ATA_READ_DMA;
            if (wide) begin
                it.fis_lba     = cur_lba;
                it.fis_count   = chunk[15:0];
                it.device_byte = DEVICE_LBA;
            end else begin
                it.fis_lba     = {24'd0, cur_lba[23:0]};
                it.fis_count   = {8'd0, chunk[7:0]};
                it.device_byte = DEVICE_LBA | {4'd0, cur_lba[27:24]};
            end
            it.write_flag  = op[0];
            it.entry_total = n_entries[ENTRY_TOTAL_W-1:0];
            run_items_due.push_back(it);

            // One scatter entry per PRD-sized piece, interrupt on the last
            cursor = cur_addr;
            for (k = 0; k < n_entries; k++) begin
                piece = (bytes_left > PRD_MAX_BYTES) ? 32'(PRD_MAX_BYTES) : bytes_left;
                bytes_left = bytes_left - piece;
                it = '0;
                it.item_kind            = KIND_ENTRY;
                it.entry_address        = cursor;
                it.entry_bytes_less_one = 22'(piece - 1);
                it.entry_interrupt      = (bytes_left == 0);
                run_items_due.push_back(it);
                cursor = cursor + {32'd0, piece};
            end

            left     = left - chunk[COUNT_W-1:0];
            cur_lba  = cur_lba + {16'd0, chunk};
            cur_addr = cur_addr + {32'd0, chunk * SECTOR_BYTES};
        end
        push_status(1'b0);
    endtask

    // Offers one request; returns once it has been taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [LBA_W-1:0] lba,
                                input logic [COUNT_W-1:0] cnt, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, addr, cnt, lba};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_run(op, lba, cnt, addr);
    endtask

    // Lowers valid and waits until every owed item has come back
    task automatic wait_runs_done();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (run_items_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_LBA48)
            model_lba48 = data[0];
        else
            model_capacity = data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic lba48, input logic [LBA_W-1:0] cap);
        wait_runs_done();
        // upper bits of the enable register are don't-care
        write_reg(CFG_LBA48, {(CFG_DATA_W - 1)'({$urandom, $urandom}), lba48});
        write_reg(CFG_CAPACITY, cap);
    endtask

    // Random start sector, mostly inside the capacity
    function automatic logic [LBA_W-1:0] pick_lba();
        logic [63:0] r;
        int          roll;
        r    = {$urandom, $urandom};
        roll = $urandom_range(9);
        if (roll < 6)
            return LBA_W'(r % ({16'd0, model_capacity} + 64'd1));
        else if (roll < 8)
            return 48'h0000_0FFF_FF00 + LBA_W'($urandom_range(511));
        else if (roll == 8)
            return r[LBA_W-1:0];
        else
            return model_capacity - LBA_W'($urandom_range(70000));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return COUNT_W'($urandom_range(300));
        else if (roll < 8)
            return COUNT_W'($urandom_range(70000));
        else if (roll == 8)
            return COUNT_W'($urandom_range(MAX_SECTORS));
        else
            return COUNT_W'($urandom_range(524287));
    endfunction

    task automatic send_random_request();
        logic [OP_W-1:0] op;
        int              roll;
        roll = $urandom_range(9);
        if (roll < 4)
            op = OP_READ;
        else if (roll < 8)
            op = OP_WRITE;
        else if (roll == 8)
            op = OP_FLUSH;
        else
            op = OP_SPARE;
        send_request(op, pick_lba(), pick_count(), {$urandom, $urandom});
    endtask

    // Registers straight out of reset: zero capacity, 28-bit device
    task automatic test_reset_state();
        send_request(OP_READ, 48'd0, 19'd0, 64'd0);
        send_request(OP_READ, 48'd0, 19'd1, 64'd0);
        send_request(OP_FLUSH, LBA_TOP, 19'h7FFFF, '1);
        send_request(OP_WRITE, 48'd5, 19'd0, 64'h1000);
    endtask

    // 28-bit form: LBA above bit 27 dropped, count keeps its low byte
    task automatic test_short_form();
        set_config(1'b0, LBA_TOP);
        send_request(OP_READ, 48'd0, 19'd1, 64'd0);
        send_request(OP_WRITE, 48'h0000_0FFF_FFFF, 19'd1, '1);
        send_request(OP_READ, 48'hABCD_EF12_3456, 19'd256, 64'h0123_4567_89AB_CDEF);
        send_request(OP_WRITE, 48'd0, 19'd65536, 64'hFFFF_FFFF_FFE0_0000);
        send_request(OP_SPARE, 48'd7, 19'd3, 64'd9);
    endtask

    // 48-bit form, largest request, and the too-many-sectors rejects
    task automatic test_long_form();
        set_config(1'b1, LBA_TOP);
        send_request(OP_READ, 48'h0000_0FFF_FFFF, 19'd255, 64'h8000);
        send_request(OP_READ, 48'h0000_1000_0000, 19'd1, 64'h0);
        send_request(OP_WRITE, 48'd0, 19'd256, 64'h4000_0000);
        send_request(OP_FLUSH, 48'd0, 19'd0, 64'd0);
        send_request(OP_SPARE, 48'd0, 19'd0, 64'd0);
        send_request(OP_WRITE, LBA_TOP - 48'(MAX_SECTORS), 19'(MAX_SECTORS),
                     64'hFFFF_FFFF_FF00_0000);
        send_request(OP_READ, 48'd0, 19'(MAX_SECTORS + 1), 64'd0);
        send_request(OP_READ, 48'd0, 19'h7FFFF, 64'd0);
        send_request(OP_READ, 48'h1234, 19'd8193, 64'hFFFF_FFFF_FFFF_FE00);
    endtask

    // Requests ending exactly at, and one past, the capacity
    task automatic test_capacity_edge();
        set_config(1'b0, 48'd1000);
        send_request(OP_READ, 48'd990, 19'd10, 64'h100);
        send_request(OP_WRITE, 48'd990, 19'd11, 64'h100);
        send_request(OP_READ, 48'd1000, 19'd0, 64'h0);
        send_request(OP_READ, 48'd1001, 19'd0, 64'h0);
        set_config(1'b1, LBA_TOP);
        send_request(OP_WRITE, LBA_TOP, 19'd0, 64'h0);
        send_request(OP_WRITE, LBA_TOP, 19'd1, 64'h0);
    endtask

    task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
        sender_idle_pct = send_pct;
        recv_stall_pct  = recv_pct;
        repeat (n_items)
            send_random_request();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 20;
        hold_trigger++;
        repeat (10)
            send_random_request();
    endtask

    // Receiver ready pattern, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_trigger != hold_ack) begin
            hold_ack      <= hold_trigger;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Score each taken output item against the oldest owed one
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.item_kind            = m_axis_tuser;
            got.ata_opcode           = m_axis_tdata[7:0];
            got.fis_lba              = m_axis_tdata[55:8];
            got.fis_count            = m_axis_tdata[71:56];
            got.device_byte          = m_axis_tdata[79:72];
            got.write_flag           = m_axis_tdata[80];
            got.entry_total          = m_axis_tdata[84:81];
            got.entry_address        = m_axis_tdata[148:85];
            got.entry_bytes_less_one = m_axis_tdata[170:149];
            got.entry_interrupt      = m_axis_tdata[171];
            got.status               = m_axis_tdata[172];
            got.last                 = m_axis_tlast;
            if (run_items_due.size() == 0) begin
                note_failure({"unexpected item ", describe_item(got)});
            end else begin
                want = run_items_due.pop_front();
                if (got !== want)
                    note_failure({"\n  expected ", describe_item(want),
                                  "\n  actual   ", describe_item(got)});
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_LBA48;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_READ;
        m_axis_tready   = 1'b0;
        model_lba48     = 1'b0;
        model_capacity  = '0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_trigger    = 0;
        hold_ack        = 0;
        hold_left       = 0;
        quiet_cycles    = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_short_form();
        test_long_form();
        test_capacity_edge();

        set_config(1'b1, LBA_TOP);
        test_random_phase(85, 0, 0);
        set_config(1'b0, LBA_W'({$urandom, $urandom}));
        test_random_phase(85, 58, 0);
        set_config(1'b1, 48'h0000_0FFF_0000 + LBA_W'($urandom_range(32'h20000)));
        test_random_phase(85, 0, 58);
        set_config(1'b1, LBA_W'({$urandom, $urandom}));
        test_random_phase(85, 30, 30);
        test_backpressure();

        // Let the last runs drain, then a short settle
        wait_runs_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (run_items_due.size() != 0)
            note_failure($sformatf("%0d items never arrived", run_items_due.size()));

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
